[rtl/core/distinct_source_window_alarm_defines.svh]
// Assertion macros for the distinct-source window alarm.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DISTINCT_SOURCE_WINDOW_ALARM_DEFINES_SVH
`define DISTINCT_SOURCE_WINDOW_ALARM_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DSWA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DSWA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dswa_pkg.sv]
// Shared widths, reset values and register codes for the distinct-source window alarm.
// No dependencies.
package dswa_pkg;

  localparam int ENTRIES_DEFAULT = 3;

  localparam int ADDR_W     = 16;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 5;
  localparam int THRESH_W   = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [TIME_W-1:0]   WINDOW_RESET    = 32'd3840;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 5'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_THRESHOLD = 1'b1;

  // item actions
  localparam logic ACT_CLICK = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

endpackage

[rtl/core/distinct_source_window_alarm.sv]
// Distinct-source window alarm: source table, activity count and alarm flag.
// Depends on dswa_pkg and distinct_source_window_alarm_defines.svh.
// ---------------------------------------------------------------------------
// Usage: raise start for one cycle per item; busy stays low, so an item may be
// transferred on every clock edge. The item is captured in an input register,
// and the table update, activity count and alarm decision are made in one pass
// of combinational logic that lands in the result register on the next edge.
// Each item therefore gives exactly one result, with done high for a single
// cycle once the result is in the result register; one item per cycle is
// sustained. The receiver cannot hold results off and must sample alarm and
// active_count while done is high. The table holds ENTRIES sources; all of them
// are compared in parallel, so ENTRIES sets the width of the compare and
// count logic rather than the rate. Configuration writes (cfg_write) take
// effect at once and should only be issued with no item in flight.
// ---------------------------------------------------------------------------
`include "distinct_source_window_alarm_defines.svh"

module distinct_source_window_alarm
  import dswa_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // item transfer
  input  logic                  start,
  output logic                  busy,
  input  logic                  action,
  input  logic [ADDR_W-1:0]     source_address,
  input  logic [TIME_W-1:0]     current_time,
  // result transfer
  output logic                  done,
  output logic                  alarm,
  output logic [COUNT_W-1:0]    active_count,
  // configuration writes
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  // configuration registers
  logic [TIME_W-1:0]   window_ticks;
  logic [THRESH_W-1:0] alarm_threshold;

  // input register
  logic              in_valid;
  logic              in_action;
  logic [ADDR_W-1:0] in_address;
  logic [TIME_W-1:0] in_time;

  // source table; entries at or above the fill count are never trusted
  logic [ADDR_W-1:0] entry_address [ENTRIES];
  logic [TIME_W-1:0] entry_time    [ENTRIES];
  logic [CNT_W-1:0]  filled;
  logic [CNT_W-1:0]  filled_next;

  logic               alarm_flag_q;
  logic               alarm_next;
  logic [COUNT_W-1:0] count_next;

  logic               click;
  logic               any_hit;
  logic               full;
  logic [ENTRIES-1:0] entry_valid;
  logic [ENTRIES-1:0] hit;
  logic [ENTRIES-1:0] oldest;
  logic [ENTRIES-1:0] write_en;
  logic [ENTRIES-1:0] active;

  // never stalls the sender
  assign busy  = 1'b0;
  assign alarm = alarm_flag_q;

  // ---- configuration -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks    <= WINDOW_RESET;
      alarm_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_TICKS:    window_ticks    <= cfg_data[TIME_W-1:0];
        REG_ALARM_THRESHOLD: alarm_threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- input register ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_action  <= action;
      in_address <= source_address;
      in_time    <= current_time;
    end
  end

  // ---- table lookup and victim choice --------------------------------------
  // The victim is the lowest index holding the smallest raw time: an entry
  // wins if it is strictly older than every entry below it and no newer than
  // every entry above it. Done as a pairwise compare matrix, no scan chain.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      entry_valid[i] = CNT_W'(i) < filled;
      hit[i]         = entry_valid[i] && (entry_address[i] == in_address);
      oldest[i]      = 1'b1;
      for (int j = 0; j < ENTRIES; j++) begin
        if (j < i) begin
          oldest[i] = oldest[i] && (entry_time[i] < entry_time[j]);
        end else if (j > i) begin
          oldest[i] = oldest[i] && (entry_time[i] <= entry_time[j]);
        end
      end
    end
  end

  assign click   = in_valid && (in_action == ACT_CLICK);
  assign any_hit = |hit;
  assign full    = filled == CNT_W'(ENTRIES);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (any_hit) begin
        write_en[i] = click && hit[i];
      end else if (!full) begin
        write_en[i] = click && (CNT_W'(i) == filled);
      end else begin
        write_en[i] = click && oldest[i];
      end
    end
  end

  assign filled_next = (click && !any_hit && !full) ? filled + CNT_W'(1) : filled;

  // ---- activity count over the updated table -------------------------------
  // A freshly written entry has age zero, so it always counts.
  always_comb begin
    count_next = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      active[i] = (CNT_W'(i) < filled_next) &&
                  (write_en[i] || ((in_time - entry_time[i]) <= window_ticks));
      count_next = count_next + COUNT_W'(active[i]);
    end
  end

  // clicks only raise, checks only clear
  always_comb begin
    alarm_next = alarm_flag_q;
    if (in_valid) begin
      if (in_action == ACT_CLICK) begin
        if (count_next >= alarm_threshold) alarm_next = 1'b1;
      end else begin
        if (count_next < alarm_threshold) alarm_next = 1'b0;
      end
    end
  end

  // ---- state and result registers ------------------------------------------
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (write_en[i]) begin
        entry_address[i] <= in_address;
        entry_time[i]    <= in_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled       <= '0;
      alarm_flag_q <= 1'b0;
      done         <= 1'b0;
    end else begin
      filled       <= filled_next;
      alarm_flag_q <= alarm_next;
      done         <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      active_count <= count_next;
    end
  end

  // ---- checks --------------------------------------------------------------
  `DSWA_ASSERT_NEXT(a_item_gives_result, clk, rst, in_valid, done, "item gave no result")
  `DSWA_ASSERT_NEXT(a_no_spurious_result, clk, rst, !in_valid, !done, "result without item")
  `DSWA_ASSERT_NOW(a_count_bounded, clk, rst, done, active_count <= COUNT_W'(ENTRIES), "count above table size")
  `DSWA_ASSERT_NOW(a_fill_bounded, clk, rst, 1'b1, filled <= CNT_W'(ENTRIES), "fill count overran table")

endmodule

[test/distinct_source_window_alarm_test.sv]
// Self-checking testbench for distinct_source_window_alarm: a directed run, then random phases.
// Needs dswa_pkg and the block itself; a built-in predictor checks every result.
module distinct_source_window_alarm_test;
  import dswa_pkg::*;

  localparam int N_SLOTS    = ENTRIES_DEFAULT;
  localparam int N_PHASES   = 24;
  localparam int PHASE_LEN  = 64;
  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
  } click_item_t;

  typedef struct packed {
    logic               alarm;
    logic [COUNT_W-1:0] count;
  } alarm_result_t;

  // block inputs, all known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  action = ACT_CLICK;
  logic [ADDR_W-1:0]     source_address = '0;
  logic [TIME_W-1:0]     current_time = '0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW_TICKS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  busy;
  logic                  done;
  logic                  alarm;
  logic [COUNT_W-1:0]    active_count;

  distinct_source_window_alarm i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .source_address (source_address),
    .current_time   (current_time),
    .done           (done),
    .alarm          (alarm),
    .active_count   (active_count),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Stimulus and scoreboard storage
  click_item_t   pending_events[$];
  alarm_result_t expected_alarms[$];
  click_item_t   drive_item;
  int            n_queued;
  int            n_accepted;
  int            n_errors;
  int            idle_cycles;
  int            burst_left = 1;
  int            gap_left;
  bit            took;
  logic [TIME_W-1:0] stim_time;

  // Predictor copy of the source table, the alarm flag and both registers
  logic [ADDR_W-1:0]   tbl_addr[N_SLOTS];
  logic [TIME_W-1:0]   tbl_time[N_SLOTS];
  int                  tbl_filled;
  logic                pred_alarm;
  logic [TIME_W-1:0]   cfg_window;
  logic [THRESH_W-1:0] cfg_thresh;

  // Applies one item to the predictor state and returns what the block should report.
  function automatic alarm_result_t predict_alarm(input click_item_t it);
    alarm_result_t     r;
    int                hit;
    int                oldest;
    logic [COUNT_W-1:0] n;
    logic [TIME_W-1:0] age;
    hit = -1;
    oldest = 0;
    n = '0;
    if (it.action == ACT_CLICK) begin
      for (int i = 0; i < tbl_filled; i++)
        if (hit < 0 && tbl_addr[i] == it.addr) hit = i;
      if (hit >= 0) begin
        tbl_time[hit] = it.now;
      end else if (tbl_filled < N_SLOTS) begin
        tbl_addr[tbl_filled] = it.addr;
        tbl_time[tbl_filled] = it.now;
        tbl_filled++;
      end else begin
        // oldest by raw timestamp, wrap ignored; first index wins a tie
        for (int i = 1; i < N_SLOTS; i++)
          if (tbl_time[i] < tbl_time[oldest]) oldest = i;
        tbl_addr[oldest] = it.addr;
        tbl_time[oldest] = it.now;
      end
    end
    for (int i = 0; i < tbl_filled; i++) begin
      age = it.now - tbl_time[i];
      if (age <= cfg_window) n++;
    end
    // a click can only raise, a check can only clear
    if (it.action == ACT_CLICK && n >= cfg_thresh) pred_alarm = 1'b1;
    if (it.action == ACT_CHECK && n < cfg_thresh) pred_alarm = 1'b0;
    r.alarm = pred_alarm;
    r.count = n;
    return r;
  endfunction

  // Driver: inputs move on the falling edge. An item stays on the ports until its
  // transfer has been seen at a rising edge; bursts of items alternate with gaps.
  always @(negedge clk) begin
    if (!start || took) begin
      if (gap_left == 0 && pending_events.size() != 0) begin
        drive_item = pending_events.pop_front();
        start <= 1'b1;
        action <= drive_item.action;
        source_address <= drive_item.addr;
        current_time <= drive_item.now;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        if (gap_left != 0) gap_left--;
        // junk on the payload while start is low; it must be ignored
        start <= 1'b0;
        action <= 1'($urandom_range(0, 1));
        source_address <= ADDR_W'($urandom);
        current_time <= $urandom;
      end
    end
  end

  // Monitor: everything sampled on the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    took = 1'b0;
    if (rst) begin
      tbl_filled = 0;
      pred_alarm = 1'b0;
      cfg_window = WINDOW_RESET;
      cfg_thresh = THRESHOLD_RESET;
      for (int i = 0; i < N_SLOTS; i++) begin
        tbl_addr[i] = '0;
        tbl_time[i] = '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WINDOW_TICKS:    cfg_window = cfg_data[TIME_W-1:0];
          REG_ALARM_THRESHOLD: cfg_thresh = cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end
      // results first: the result register lies behind the input register, so a
      // result never belongs to the item transferred at this same edge
      if (done) begin
        if (expected_alarms.size() == 0) begin
          $display("%0t: result with no item outstanding: alarm %0b active_count %0d",
                   $time, alarm, active_count);
          n_errors++;
        end else begin
          alarm_result_t e;
          e = expected_alarms.pop_front();
          if (alarm !== e.alarm) begin
            $display("%0t: alarm mismatch: expected %0b, got %0b", $time, e.alarm, alarm);
            n_errors++;
          end
          if (active_count !== e.count) begin
            $display("%0t: active_count mismatch: expected %0d, got %0d",
                     $time, e.count, active_count);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        click_item_t it;
        took = 1'b1;
        n_accepted++;
        it.action = action;
        it.addr = source_address;
        it.now = current_time;
        expected_alarms.push_back(predict_alarm(it));
      end
    end
    // watchdog: only counts while work is outstanding
    if (took || done || (pending_events.size() == 0 && expected_alarms.size() == 0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_item(input logic act, input logic [ADDR_W-1:0] addr,
                          input logic [TIME_W-1:0] now);
    click_item_t it;
    it.action = act;
    it.addr = addr;
    it.now = now;
    pending_events.push_back(it);
    n_queued++;
  endtask

  // Holds the sender back until every queued item is transferred and answered.
  task automatic wait_drained();
    @(negedge clk);
    while (n_accepted != n_queued || expected_alarms.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly clicks from a small pool of sources with time moving forward on the
  // scale of the window, some checks, and a share of noise over the full ranges.
  task automatic queue_phase(input int n_items, input logic [TIME_W-1:0] win);
    logic [ADDR_W-1:0] pool[6];
    int                pool_n;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] step;
    int                pick;
    pool_n = $urandom_range(3, 6);
    for (int i = 0; i < 6; i++) pool[i] = ADDR_W'($urandom);
    span = (win > 32'h00FF_FFFF) ? 32'h00FF_FFFF : win;
    // now and then start just short of the wrap
    if ($urandom_range(0, 3) == 0)
      stim_time = 32'hFFFF_FFFF - $urandom_range(0, 4 * span);
    else
      stim_time = $urandom;
    for (int k = 0; k < n_items; k++) begin
      case ($urandom_range(0, 3))
        0: step = 0;
        1: step = $urandom_range(0, span);
        2: step = $urandom_range(0, 2 * span + 1);
        default: step = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, span / 4);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        stim_time = stim_time + step;
        add_item(ACT_CLICK, pool[$urandom_range(0, pool_n - 1)], stim_time);
      end else if (pick < 86) begin
        stim_time = stim_time + step;
        add_item(ACT_CHECK, ADDR_W'($urandom), stim_time);
      end else begin
        add_item(1'($urandom_range(0, 1)), ADDR_W'($urandom), $urandom);
      end
    end
  endtask

  initial begin : main
    logic [TIME_W-1:0]   win;
    logic [THRESH_W-1:0] thr;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed run at the reset settings (window 3840, threshold 3)
    add_item(ACT_CLICK, 16'h0000, 32'd0);
    add_item(ACT_CLICK, 16'hFFFF, 32'd100);       // below threshold, alarm stays low
    add_item(ACT_CHECK, 16'hFFFF, 32'd100);
    add_item(ACT_CLICK, 16'h1234, 32'd200);       // third source raises the alarm
    add_item(ACT_CHECK, 16'h0000, 32'd200);       // at threshold: check leaves it set
    add_item(ACT_CLICK, 16'h0000, 32'd300);       // known source, time refreshed
    add_item(ACT_CLICK, 16'h5555, 32'd400);       // table full: oldest raw time goes
    add_item(ACT_CHECK, 16'h0000, 32'd4140);      // age exactly at the window edge
    add_item(ACT_CHECK, 16'h0000, 32'd4141);
    add_item(ACT_CLICK, 16'hAAAA, 32'd6000);
    add_item(ACT_CLICK, 16'h0F0F, 32'd6000);
    add_item(ACT_CLICK, 16'hF0F0, 32'd6000);      // all three stamps equal
    add_item(ACT_CLICK, 16'h0001, 32'd6000);      // tie: lowest index replaced
    add_item(ACT_CLICK, 16'h0002, 32'hFFFF_FF00);
    add_item(ACT_CHECK, 16'h0000, 32'h0000_0010); // age across the wrap
    add_item(ACT_CLICK, 16'h0003, 32'h0000_0020); // oldest chosen by raw value
    add_item(ACT_CLICK, 16'h0004, 32'hFFFF_FFFF);
    add_item(ACT_CHECK, 16'hFFFF, 32'hFFFF_FFFF);
    wait_drained();

    // Random phases; the sender is held at each boundary so the registers
    // are only touched with nothing in flight.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin win = 32'd0;          thr = 5'd1;  end
        1: begin win = 32'hFFFF_FFFF;  thr = 5'd3;  end
        2: begin win = 32'd3840;       thr = 5'd0;  end  // every click raises
        3: begin win = 32'd3840;       thr = 5'd4;  end  // above table size: never raised
        4: begin win = 32'd500;        thr = 5'd31; end
        5: begin win = WINDOW_RESET;   thr = 5'd16; end
        default: begin
          case ($urandom_range(0, 5))
            0: win = 32'd0;
            1: win = 32'hFFFF_FFFF;
            2: win = $urandom;
            3: win = WINDOW_RESET;
            default: win = $urandom_range(1, 20000);
          endcase
          thr = ($urandom_range(0, 7) == 0) ? THRESH_W'($urandom_range(0, 31))
                                            : THRESH_W'($urandom_range(1, 4));
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_WINDOW_TICKS, win);
        write_reg(REG_ALARM_THRESHOLD, ($urandom & 32'hFFFF_FFE0) | thr);
      end else begin
        write_reg(REG_ALARM_THRESHOLD, ($urandom & 32'hFFFF_FFE0) | thr);
        write_reg(REG_WINDOW_TICKS, win);
      end
      queue_phase(PHASE_LEN, win);
      wait_drained();
    end

    repeat (6) @(posedge clk);
    if (n_errors == 0 && expected_alarms.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/dswa_pkg.sv
rtl/core/distinct_source_window_alarm.sv
test/distinct_source_window_alarm_test.sv
